>>> sv/hpt_pkg.sv
// Shared constants and types for the homogeneous point transform.
package hpt_pkg;

    localparam int FIELD_W        = 32;
    localparam int CFG_W          = 64;
    localparam int CFG_N          = 8;
    localparam int CFG_IDX_W      = 4;
    localparam int ROWS           = 4;
    localparam int COLS           = 4;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef logic [CFG_N-1:0][CFG_W-1:0] t_cfg_bank;

    typedef enum logic {
        CMD_POINT = 1'b0,
        CMD_DIR   = 1'b1
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0_LEFT  = 4'd0,
        CFG_ROW0_RIGHT = 4'd1,
        CFG_ROW1_LEFT  = 4'd2,
        CFG_ROW1_RIGHT = 4'd3,
        CFG_ROW2_LEFT  = 4'd4,
        CFG_ROW2_RIGHT = 4'd5,
        CFG_ROW3_LEFT  = 4'd6,
        CFG_ROW3_RIGHT = 4'd7
    } t_cfg_reg;

endpackage

>>> sv/hpt_mac.sv
// Matrix-vector product: one stage of products, one stage of row sums with floor to Q format.
module hpt_mac #(
    parameter int DATA_WIDTH = hpt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF,
    localparam int ACC_W     = 2 * DATA_WIDTH + 2 - FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_dir,
    input  logic signed [hpt_pkg::FIELD_W-1:0] i_vx,
    input  logic signed [hpt_pkg::FIELD_W-1:0] i_vy,
    input  logic signed [hpt_pkg::FIELD_W-1:0] i_vz,
    input  logic signed [hpt_pkg::FIELD_W-1:0] i_w,
    input  hpt_pkg::t_cfg_bank                i_cfg,
    output logic signed [ACC_W-1:0]           o_acc [hpt_pkg::ROWS]
);
    import hpt_pkg::*;

    localparam int PW = 2 * DATA_WIDTH;
    localparam int SW = 2 * DATA_WIDTH + 2;

    logic signed [DATA_WIDTH-1:0] vec [COLS];
    logic signed [DATA_WIDTH-1:0] ent [ROWS][COLS];
    logic signed [PW-1:0]         r_prod [ROWS][COLS];
    logic signed [SW-1:0]         sum [ROWS];
    logic signed [ACC_W-1:0]      r_acc [ROWS];

    always_comb begin
        vec[0] = i_vx[DATA_WIDTH-1:0];
        vec[1] = i_vy[DATA_WIDTH-1:0];
        vec[2] = i_vz[DATA_WIDTH-1:0];
        // drop the translation column for directions
        vec[3] = i_dir ? '0 : i_w[DATA_WIDTH-1:0];
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                ent[r][c] = i_cfg[r * 2 + c / 2][(c % 2) * (CFG_W / 2) +: DATA_WIDTH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < ROWS; r++) begin
                for (int c = 0; c < COLS; c++) begin
                    r_prod[r][c] <= ent[r][c] * vec[c];
                end
            end
        end
    end

    always_comb begin
        for (int r = 0; r < ROWS; r++) begin
            sum[r] = '0;
            for (int c = 0; c < COLS; c++) begin
                sum[r] = sum[r] + SW'(r_prod[r][c]);
            end
        end
    end

    // arithmetic floor of the exact sum
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int r = 0; r < ROWS; r++) begin
                r_acc[r] <= sum[r][SW-1:FRAC_BITS];
            end
        end
    end

    assign o_acc = r_acc;

endmodule

>>> sv/hpt_div_lane.sv
// Pipelined restoring divider lane: one quotient bit per stage.
module hpt_div_lane #(
    parameter int NUM_W = 66,
    parameter int DEN_W = 50,
    parameter int QUO_W = 33
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo
);
    localparam int CMP_W = ((NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W) + 1;

    logic [NUM_W-1:0] r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        logic [NUM_W-1:0] rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [CMP_W-1:0] trial;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = '0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        assign trial = CMP_W'(rem_in) - (CMP_W'(den_in) << (QUO_W - 1 - s));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_quo[s] <= {quo_in[QUO_W-2:0], ~trial[CMP_W-1]};
            end
        end

        if (s < QUO_W - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[s] <= trial[CMP_W-1] ? rem_in : trial[NUM_W-1:0];
                    r_den[s] <= den_in;
                end
            end
        end else begin : g_last
            assign r_rem[s] = '0;
            assign r_den[s] = '0;
        end
    end

    assign o_quo = r_quo[QUO_W-1];

endmodule

>>> sv/homogeneous_point_transform.sv
// Fully pipelined 4x4 homogeneous transform: accepts one beat per clock while not stalled, with
// two multiply/sum stages, one prepare stage, one restoring divider stage per quotient bit and
// one saturate stage; the divider makes up most of the stages. A stall on the output
// freezes the whole pipeline, so throughput stays one beat per cycle otherwise.
module homogeneous_point_transform #(
    parameter int DATA_WIDTH = hpt_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hpt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpt_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [hpt_pkg::FIELD_W-1:0]  i_vx,
    input  logic signed [hpt_pkg::FIELD_W-1:0]  i_vy,
    input  logic signed [hpt_pkg::FIELD_W-1:0]  i_vz,
    input  logic signed [hpt_pkg::FIELD_W-1:0]  i_w,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [hpt_pkg::FIELD_W-1:0]  o_rx,
    output logic signed [hpt_pkg::FIELD_W-1:0]  o_ry,
    output logic signed [hpt_pkg::FIELD_W-1:0]  o_rz,
    output logic                                o_divide_by_zero,
    output logic                                o_overflow
);
    import hpt_pkg::*;

    localparam int ACC_W = 2 * DATA_WIDTH + 2 - FRAC_BITS;
    localparam int NUM_W = ACC_W + FRAC_BITS;
    localparam int QUO_W = DATA_WIDTH + 1;
    localparam int CMP_W = ((NUM_W > ACC_W + QUO_W) ? NUM_W : ACC_W + QUO_W) + 1;
    localparam int LANES = 3;
    localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [CFG_W-1:0] ONE_LO = CFG_W'(1) << FRAC_BITS;
    localparam logic [CFG_W-1:0] ONE_HI = CFG_W'(1) << (FRAC_BITS + CFG_W / 2);

    t_cfg_bank r_cfg;
    logic      en;

    logic r_m_valid [2];
    logic r_m_dir   [2];
    logic signed [ACC_W-1:0] acc [ROWS];

    // prepare stage
    logic                    r_p_valid, r_p_dir, r_p_dz;
    logic [ACC_W-1:0]        r_p_den;
    logic [NUM_W-1:0]        r_p_num  [LANES];
    logic                    r_p_neg  [LANES];
    logic                    r_p_ovq  [LANES];
    logic [DATA_WIDTH-1:0]   r_p_dval [LANES];
    logic                    r_p_dov;

    logic [ACC_W-1:0]        den_mag;
    logic [ACC_W-1:0]        num_mag  [LANES];
    logic [DATA_WIDTH-1:0]   n_p_dval [LANES];
    logic                    n_p_dov;

    // divider-aligned sideband
    logic                    r_d_valid [QUO_W];
    logic                    r_d_dir   [QUO_W];
    logic                    r_d_dz    [QUO_W];
    logic                    r_d_dov   [QUO_W];
    logic                    r_d_neg   [QUO_W][LANES];
    logic                    r_d_ovq   [QUO_W][LANES];
    logic [DATA_WIDTH-1:0]   r_d_dval  [QUO_W][LANES];
    logic [QUO_W-1:0]        quo       [LANES];

    logic [DATA_WIDTH-1:0]   n_res [LANES];
    logic                    n_ov;
    logic                    r_out_valid, r_out_dz, r_out_ov;
    logic [DATA_WIDTH-1:0]   r_out_res [LANES];

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[CFG_ROW0_LEFT]  <= ONE_LO;
            r_cfg[CFG_ROW0_RIGHT] <= '0;
            r_cfg[CFG_ROW1_LEFT]  <= ONE_HI;
            r_cfg[CFG_ROW1_RIGHT] <= '0;
            r_cfg[CFG_ROW2_LEFT]  <= '0;
            r_cfg[CFG_ROW2_RIGHT] <= ONE_LO;
            r_cfg[CFG_ROW3_LEFT]  <= '0;
            r_cfg[CFG_ROW3_RIGHT] <= ONE_HI;
        end else if (i_cfg_we && i_cfg_index < CFG_IDX_W'(CFG_N)) begin
            r_cfg[i_cfg_index[CFG_IDX_W-2:0]] <= i_cfg_data;
        end
    end

    hpt_mac #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk(i_clk),
        .i_en (en),
        .i_dir(i_command == CMD_DIR),
        .i_vx (i_vx),
        .i_vy (i_vy),
        .i_vz (i_vz),
        .i_w  (i_w),
        .i_cfg(r_cfg),
        .o_acc(acc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid[0] <= 1'b0;
            r_m_valid[1] <= 1'b0;
        end else if (en) begin
            r_m_valid[0] <= i_valid;
            r_m_valid[1] <= r_m_valid[0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_dir[0] <= (i_command == CMD_DIR);
            r_m_dir[1] <= r_m_dir[0];
        end
    end

    // magnitudes, direction-mode saturation, quotient range check
    always_comb begin
        den_mag = acc[3][ACC_W-1] ? ACC_W'(-acc[3]) : ACC_W'(acc[3]);
        n_p_dov = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            num_mag[l] = acc[l][ACC_W-1] ? ACC_W'(-acc[l]) : ACC_W'(acc[l]);
            if ((&acc[l][ACC_W-1:DATA_WIDTH-1]) || !(|acc[l][ACC_W-1:DATA_WIDTH-1])) begin
                n_p_dval[l] = acc[l][DATA_WIDTH-1:0];
            end else begin
                n_p_dval[l] = acc[l][ACC_W-1] ? SAT_MIN : SAT_MAX;
                n_p_dov     = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (en) begin
            r_p_valid <= r_m_valid[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_dir <= r_m_dir[1];
            r_p_dz  <= !r_m_dir[1] && (acc[3] == '0);
            r_p_den <= den_mag;
            r_p_dov <= n_p_dov;
            for (int l = 0; l < LANES; l++) begin
                r_p_num[l]  <= {num_mag[l], {FRAC_BITS{1'b0}}};
                r_p_neg[l]  <= acc[l][ACC_W-1] ^ acc[3][ACC_W-1];
                r_p_ovq[l]  <= CMP_W'({num_mag[l], {FRAC_BITS{1'b0}}}) >=
                               (CMP_W'(den_mag) << QUO_W);
                r_p_dval[l] <= n_p_dval[l];
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        hpt_div_lane #(
            .NUM_W(NUM_W),
            .DEN_W(ACC_W),
            .QUO_W(QUO_W)
        ) u_div (
            .i_clk(i_clk),
            .i_en (en),
            .i_num(r_p_num[l]),
            .i_den(r_p_den),
            .o_quo(quo[l])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < QUO_W; s++) begin
                r_d_valid[s] <= 1'b0;
            end
        end else if (en) begin
            r_d_valid[0] <= r_p_valid;
            for (int s = 1; s < QUO_W; s++) begin
                r_d_valid[s] <= r_d_valid[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d_dir[0] <= r_p_dir;
            r_d_dz[0]  <= r_p_dz;
            r_d_dov[0] <= r_p_dov;
            for (int l = 0; l < LANES; l++) begin
                r_d_neg[0][l]  <= r_p_neg[l];
                r_d_ovq[0][l]  <= r_p_ovq[l];
                r_d_dval[0][l] <= r_p_dval[l];
            end
            for (int s = 1; s < QUO_W; s++) begin
                r_d_dir[s]  <= r_d_dir[s-1];
                r_d_dz[s]   <= r_d_dz[s-1];
                r_d_dov[s]  <= r_d_dov[s-1];
                r_d_neg[s]  <= r_d_neg[s-1];
                r_d_ovq[s]  <= r_d_ovq[s-1];
                r_d_dval[s] <= r_d_dval[s-1];
            end
        end
    end

    // pick direction value, zero on W zero, or signed saturated quotient
    always_comb begin
        n_ov = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            if (r_d_dir[QUO_W-1]) begin
                n_res[l] = r_d_dval[QUO_W-1][l];
            end else if (r_d_dz[QUO_W-1]) begin
                n_res[l] = '0;
            end else if (r_d_neg[QUO_W-1][l]) begin
                if (r_d_ovq[QUO_W-1][l] || quo[l] > (QUO_W'(1) << (DATA_WIDTH - 1))) begin
                    n_res[l] = SAT_MIN;
                    n_ov     = 1'b1;
                end else begin
                    n_res[l] = DATA_WIDTH'(-quo[l]);
                end
            end else begin
                if (r_d_ovq[QUO_W-1][l] || quo[l] > QUO_W'(SAT_MAX)) begin
                    n_res[l] = SAT_MAX;
                    n_ov     = 1'b1;
                end else begin
                    n_res[l] = quo[l][DATA_WIDTH-1:0];
                end
            end
        end
        if (r_d_dir[QUO_W-1]) begin
            n_ov = r_d_dov[QUO_W-1];
        end else if (r_d_dz[QUO_W-1]) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_d_valid[QUO_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_res <= n_res;
            r_out_dz  <= !r_d_dir[QUO_W-1] && r_d_dz[QUO_W-1];
            r_out_ov  <= n_ov;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_rx             = FIELD_W'(signed'(r_out_res[0]));
    assign o_ry             = FIELD_W'(signed'(r_out_res[1]));
    assign o_rz             = FIELD_W'(signed'(r_out_res[2]));
    assign o_divide_by_zero = r_out_dz;
    assign o_overflow       = r_out_ov;

endmodule

>>> sim/homogeneous_point_transform_tb.sv
// Self-checking testbench for the 4x4 homogeneous point and direction transform.
module homogeneous_point_transform_tb;
    import hpt_pkg::*;

    localparam int DW   = DATA_WIDTH_DEF;
    localparam int FRAC = FRAC_BITS_DEF;
    localparam logic signed [31:0] ONE_Q = 32'sh0001_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;

    typedef struct {
        t_cmd                cmd;
        logic signed [31:0]  vx, vy, vz, w;
        int unsigned         gap;
    } t_vec_beat;

    typedef struct {
        logic signed [31:0]  rx, ry, rz;
        logic                dz, ov;
    } t_xform_out;

    logic                  i_clk, i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  i_valid, o_stall, i_command;
    logic signed [31:0]    i_vx, i_vy, i_vz, i_w;
    logic                  o_valid, i_stall;
    logic signed [31:0]    o_rx, o_ry, o_rz;
    logic                  o_divide_by_zero, o_overflow;

    homogeneous_point_transform u_top (.*);

    logic [CFG_W-1:0] matrix_regs [CFG_N];
    t_vec_beat        pending_vecs[$];
    t_xform_out       expected_xforms[$];
    int               n_errors = 0;
    int unsigned      hold_cnt, stall_cnt;
    bit               busy_mode;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic signed [31:0] clamp_q(input logic signed [127:0] x, ref logic ov);
        if (x > S_MAX) begin
            ov = 1'b1;
            return S_MAX;
        end
        if (x < S_MIN) begin
            ov = 1'b1;
            return S_MIN;
        end
        return x[31:0];
    endfunction

    // floor(sum M[r][c]*v[c] / 2^FRAC), exact
    function automatic logic signed [127:0] row_acc(input int r, input t_vec_beat b, input int n);
        logic signed [127:0] s, e, vc;
        logic signed [31:0]  ent;
        s = 0;
        for (int c = 0; c < n; c++) begin
            ent = matrix_regs[r*2 + c/2][(c%2)*32 +: 32];
            e = ent;
            case (c)
                0: vc = b.vx;
                1: vc = b.vy;
                2: vc = b.vz;
                default: vc = b.w;
            endcase
            s += e * vc;
        end
        return s >>> FRAC;
    endfunction

    function automatic t_xform_out transform_vec(input t_vec_beat b);
        t_xform_out          o;
        logic signed [127:0] wsum, num, q;
        logic [127:0]        un, ud;
        logic                neg;
        o = '{0, 0, 0, 1'b0, 1'b0};
        if (b.cmd == CMD_DIR) begin
            o.rx = clamp_q(row_acc(0, b, 3), o.ov);
            o.ry = clamp_q(row_acc(1, b, 3), o.ov);
            o.rz = clamp_q(row_acc(2, b, 3), o.ov);
            return o;
        end
        wsum = row_acc(3, b, 4);
        if (wsum == 0) begin
            o.dz = 1'b1;
            return o;
        end
        ud = (wsum < 0) ? -wsum : wsum;
        for (int r = 0; r < 3; r++) begin
            num = row_acc(r, b, 4);
            neg = (num < 0) != (wsum < 0);
            un  = (num < 0) ? -num : num;
            q   = (un << FRAC) / ud;
            if (neg) q = -q;
            case (r)
                0: o.rx = clamp_q(q, o.ov);
                1: o.ry = clamp_q(q, o.ov);
                default: o.rz = clamp_q(q, o.ov);
            endcase
        end
        return o;
    endfunction

    // driver
    always @(posedge i_clk) begin
        t_vec_beat b;
        if (!i_rst_n) begin
            i_valid   <= 1'b0;
            i_command <= 1'b0;
            i_vx      <= '0;
            i_vy      <= '0;
            i_vz      <= '0;
            i_w       <= '0;
            hold_cnt  <= 0;
        end else begin
            if (i_valid && !o_stall)
                expected_xforms.push_back(transform_vec('{t_cmd'(i_command), i_vx, i_vy,
                                                          i_vz, i_w, 0}));
            if (!i_valid || !o_stall) begin
                if (hold_cnt > 0) begin
                    hold_cnt <= hold_cnt - 1;
                    i_valid  <= 1'b0;
                end else if (pending_vecs.size() > 0) begin
                    b = pending_vecs.pop_front();
                    i_valid   <= 1'b1;
                    i_command <= b.cmd;
                    i_vx      <= b.vx;
                    i_vy      <= b.vy;
                    i_vz      <= b.vz;
                    i_w       <= b.w;
                    hold_cnt  <= b.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_xform_out e;
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (expected_xforms.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    e = expected_xforms.pop_front();
                    if (o_rx !== e.rx) begin
                        $error("rx exp %h got %h", e.rx, o_rx); n_errors++;
                    end
                    if (o_ry !== e.ry) begin
                        $error("ry exp %h got %h", e.ry, o_ry); n_errors++;
                    end
                    if (o_rz !== e.rz) begin
                        $error("rz exp %h got %h", e.rz, o_rz); n_errors++;
                    end
                    if (o_divide_by_zero !== e.dz) begin
                        $error("divide_by_zero exp %b got %b", e.dz, o_divide_by_zero);
                        n_errors++;
                    end
                    if (o_overflow !== e.ov) begin
                        $error("overflow exp %b got %b", e.ov, o_overflow); n_errors++;
                    end
                end
                stall_cnt <= busy_mode ? $urandom_range(0, 10) : 0;
                i_stall   <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt <= stall_cnt - 1;
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx < CFG_N) matrix_regs[idx] = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] pick_entry(input int kind);
        case (kind)
            0: return $urandom;
            1: return S_MAX;
            2: return S_MIN;
            3: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            default: return 32'h0;
        endcase
    endfunction

    function automatic logic signed [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return ($urandom_range(0, 1)) ? S_MAX : S_MIN;
            default: return 32'($signed($urandom_range(0, 200 * 65536)) - 100 * 65536);
        endcase
    endfunction

    task automatic queue_vec(input t_cmd c, input logic signed [31:0] x, y, z, ww);
        pending_vecs.push_back('{c, x, y, z, ww,
                                 busy_mode ? $urandom_range(0, 10) : 0});
    endtask

    task automatic drain();
        while (pending_vecs.size() > 0 || i_valid || expected_xforms.size() > 0)
            @(posedge i_clk);
        repeat (DW + 10) @(posedge i_clk);
    endtask

    initial begin
        logic signed [31:0] ww;
        int                 kind;
        busy_mode   = 1'b1;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        matrix_regs = '{64'h1_0000, 0, 64'h1_0000 << 32, 0, 0, 64'h1_0000, 0, 64'h1_0000 << 32};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed beats under the identity matrix
        queue_vec(CMD_POINT, ONE_Q, 2 * ONE_Q, -3 * ONE_Q, ONE_Q);
        queue_vec(CMD_POINT, ONE_Q, ONE_Q, ONE_Q, 0);          // zero W
        queue_vec(CMD_POINT, S_MAX, S_MIN, ONE_Q, 1);          // huge quotient saturates
        queue_vec(CMD_POINT, S_MIN, S_MAX, S_MIN, -ONE_Q);
        queue_vec(CMD_POINT, S_MAX, S_MAX, S_MAX, S_MAX);
        queue_vec(CMD_POINT, S_MIN, S_MIN, S_MIN, S_MIN);
        queue_vec(CMD_POINT, 5, -7, 3, 3 * ONE_Q);             // inexact divide, both signs
        queue_vec(CMD_DIR, S_MAX, S_MIN, 0, 0);
        queue_vec(CMD_DIR, S_MIN, S_MAX, -1, S_MAX);
        queue_vec(CMD_DIR, ONE_Q, -ONE_Q, 12345, ONE_Q);
        queue_vec(CMD_DIR, 0, 0, 0, 0);
        drain();

        // matrix of extremes to force direction-mode overflow
        for (int i = 0; i < CFG_N; i++) write_reg(CFG_IDX_W'(i), {S_MAX, S_MAX});
        queue_vec(CMD_DIR, S_MAX, S_MAX, S_MAX, 0);
        queue_vec(CMD_DIR, S_MIN, S_MIN, S_MIN, 0);
        queue_vec(CMD_POINT, S_MAX, S_MIN, 1, ONE_Q);
        queue_vec(CMD_POINT, -1, 1, 0, 0);                     // W sums to zero
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            busy_mode = (ph != 3);
            for (int i = 0; i < CFG_N; i++) begin
                kind = (ph == 1) ? 2 : (ph == 2) ? 4 : $urandom_range(0, 4);
                if (kind == 4 && ph != 2) kind = 3;
                write_reg(CFG_IDX_W'(i), {pick_entry(kind), pick_entry(kind)});
            end
            // ignored index
            write_reg(CFG_IDX_W'($urandom_range(CFG_N, 15)), {$urandom, $urandom});
            for (int n = 0; n < 150; n++) begin
                case ($urandom_range(0, 7))
                    0: ww = $urandom;
                    1: ww = 0;
                    default: ww = ONE_Q;
                endcase
                queue_vec(t_cmd'($urandom_range(0, 1)), pick_coord(), pick_coord(),
                          pick_coord(), ww);
            end
            drain();
        end

        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
